// ===== rtl/request_metrics_rolling_qps_top_assert.svh =====
// Assertion macros used by the request monitor top module
`ifndef REQUEST_METRICS_ROLLING_QPS_TOP_ASSERT_SVH
`define REQUEST_METRICS_ROLLING_QPS_TOP_ASSERT_SVH
// Assert that an antecedent implies a consequent in the same cycle
`define RMQ_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Assert that an antecedent implies a consequent in the next cycle
`define RMQ_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// ===== rtl/rmqps_pkg.sv =====
// ----------------------------------------------------------------------------
// rmqps_pkg
// Types, codes and constants of the request monitor.
// ----------------------------------------------------------------------------
package rmqps_pkg;
   localparam int HistoryDepthDefault = 60;
   localparam int CodeWidth = 16;
   localparam int CntWidth = 64;
   localparam int SecWidth = 32;
   localparam int LatWidth = 32;
   localparam int SelWidth = 4;
   localparam int OpWidth = 3;
   localparam int CsrIdxWidth = 2;

   localparam logic [OpWidth-1:0] OP_REQUEST   = 3'd0;
   localparam logic [OpWidth-1:0] OP_AUTH      = 3'd1;
   localparam logic [OpWidth-1:0] OP_RATELIMIT = 3'd2;
   localparam logic [OpWidth-1:0] OP_READ      = 3'd3;
   localparam logic [OpWidth-1:0] OP_CLEAR     = 3'd4;

   localparam logic [SelWidth-1:0] SEL_TOTAL   = 4'd0;
   localparam logic [SelWidth-1:0] SEL_REG     = 4'd1;
   localparam logic [SelWidth-1:0] SEL_LOOKUP  = 4'd2;
   localparam logic [SelWidth-1:0] SEL_HB      = 4'd3;
   localparam logic [SelWidth-1:0] SEL_UNREG   = 4'd4;
   localparam logic [SelWidth-1:0] SEL_ERR     = 4'd5;
   localparam logic [SelWidth-1:0] SEL_AUTH    = 4'd6;
   localparam logic [SelWidth-1:0] SEL_RL      = 4'd7;
   localparam logic [SelWidth-1:0] SEL_PEAK    = 4'd8;
   localparam logic [SelWidth-1:0] SEL_AVG     = 4'd9;
   localparam logic [SelWidth-1:0] SEL_AVGLAT  = 4'd10;

   // divider request/response between sequencer and divider
   typedef struct packed {
      logic                start;
      logic [CntWidth-1:0] dividend;
      logic [CntWidth-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                done;
      logic [CntWidth-1:0] quotient;
   } div_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_CLEAR, ST_FLUSH_RD, ST_FLUSH_WR, ST_DIV, ST_RESP
   } state_type;
endpackage

// ===== rtl/request_metrics_rolling_qps_top.sv =====
// ----------------------------------------------------------------------------
// request_metrics_rolling_qps_top
// Request monitor with counters and a sliding per-second rate average.
// ----------------------------------------------------------------------------
// Auth, rate-limit and non-flushing requests update counters when accepted;
// reads of plain counters pass through the output register. A request that
// closes a second runs the history ring read state, then the write state
// with the running sum update. Reads of the average rate or average latency
// run the shared 64-bit bit-serial divider, whose quotient goes to the output
// register. Clear-all sweeps the history memory one entry a cycle; the same
// sweep runs after reset before the first transaction is accepted.
module request_metrics_rolling_qps_top #(
   parameter int HISTORY_DEPTH = rmqps_pkg::HistoryDepthDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_op,
   input  logic [15:0] req_msg_kind,
   input  logic signed [31:0] req_latency,
   input  logic        req_ok,
   input  logic [31:0] req_now_sec,
   input  logic [3:0]  req_counter_sel,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_counter_value,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   import rmqps_pkg::*;
   `include "request_metrics_rolling_qps_top_assert.svh"

   localparam int PosWidth = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam logic [PosWidth-1:0] PosLast = PosWidth'(HISTORY_DEPTH - 1);

   logic [CodeWidth-1:0] code_ff [4];
   logic [CntWidth-1:0] total_ff, err_ff, auth_ff, rl_ff, lat_ff, bucket_ff;
   logic [CntWidth-1:0] peak_ff, hsum_ff;
   logic [CntWidth-1:0] type_ff [5];
   logic [SecWidth-1:0] last_ff;
   logic [PosWidth-1:0] pos_ff;
   logic [CntWidth-1:0] hist_mem [HISTORY_DEPTH];
   logic [CntWidth-1:0] hist_rd_ff;
   logic [CntWidth-1:0] flush_b_ff;
   logic [SecWidth-1:0] flush_now_ff;
   logic [PosWidth-1:0] clr_ff;
   state_type           state_ff, state_in;
   logic                rsp_valid_ff;
   logic [CntWidth-1:0] rsp_data_ff;
   div_req_type         dreq;
   div_rsp_type         drsp;

   rmqps_div u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   logic accept;
   assign req_stall = (state_ff != ST_IDLE) || rsp_valid_ff;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_counter_value = rsp_data_ff;

   // classify message kind, lowest register wins
   logic [2:0] cls;
   always_comb begin
      priority if (req_msg_kind == code_ff[0]) cls = 3'd0;
      else if (req_msg_kind == code_ff[1]) cls = 3'd1;
      else if (req_msg_kind == code_ff[2]) cls = 3'd2;
      else if (req_msg_kind == code_ff[3]) cls = 3'd3;
      else cls = 3'd4;
   end

   logic [CntWidth-1:0] lat_clamp, bucket_inc, plain_val;
   assign lat_clamp  = req_latency[31] ? '0 : CntWidth'(req_latency);
   assign bucket_inc = bucket_ff + 1'b1;

   // reads that go through the divider
   logic div_read;
   assign div_read = (req_op == OP_READ) && ((req_counter_sel == SEL_AVG) ||
                     (req_counter_sel == SEL_AVGLAT && total_ff != '0));

   // mux plain counters for reads
   always_comb begin
      unique case (req_counter_sel)
         SEL_TOTAL:  plain_val = total_ff;
         SEL_REG:    plain_val = type_ff[0];
         SEL_LOOKUP: plain_val = type_ff[1];
         SEL_HB:     plain_val = type_ff[2];
         SEL_UNREG:  plain_val = type_ff[3];
         SEL_ERR:    plain_val = err_ff;
         SEL_AUTH:   plain_val = auth_ff;
         SEL_RL:     plain_val = rl_ff;
         SEL_PEAK:   plain_val = peak_ff;
         default:    plain_val = '0;
      endcase
   end

   logic [CntWidth-1:0] hsum_new;
   assign hsum_new = hsum_ff - hist_rd_ff + flush_b_ff;

   // next state and divider launch
   always_comb begin
      state_in      = state_ff;
      dreq.start    = 1'b0;
      dreq.dividend = lat_ff;
      dreq.divisor  = total_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_op == OP_CLEAR) state_in = ST_CLEAR;
            else if (accept && req_op == OP_REQUEST && req_now_sec != last_ff)
               state_in = ST_FLUSH_RD;
            else if (accept && div_read) begin
               state_in = ST_DIV;
               dreq.start = 1'b1;
               if (req_counter_sel == SEL_AVG) begin
                  dreq.dividend = hsum_ff;
                  dreq.divisor = CntWidth'(HISTORY_DEPTH);
               end
            end
         end
         ST_CLEAR:    if (clr_ff == PosLast) state_in = ST_IDLE;
         ST_FLUSH_RD: state_in = ST_FLUSH_WR;
         ST_FLUSH_WR: state_in = ST_IDLE;
         ST_DIV:      if (drsp.done) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // history memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (state_ff == ST_CLEAR) hist_mem[clr_ff] <= '0;
      else if (state_ff == ST_FLUSH_WR) hist_mem[pos_ff] <= flush_b_ff;
      hist_rd_ff <= hist_mem[pos_ff];
   end

   // counters, configuration and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         code_ff[0] <= 16'd1; code_ff[1] <= 16'd2;
         code_ff[2] <= 16'd3; code_ff[3] <= 16'd4;
         total_ff <= '0; err_ff <= '0; auth_ff <= '0; rl_ff <= '0;
         lat_ff <= '0; bucket_ff <= '0; peak_ff <= '0;
         hsum_ff <= '0; last_ff <= '0; pos_ff <= '0;
         for (int i = 0; i < 5; i++) type_ff[i] <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid) code_ff[csr_index] <= csr_data;
         if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         if (state_ff == ST_CLEAR) clr_ff <= (clr_ff == PosLast) ? '0 : clr_ff + 1'b1;
         if (accept) begin
            unique case (req_op)
               OP_REQUEST: begin
                  total_ff <= total_ff + 1'b1;
                  type_ff[cls] <= type_ff[cls] + 1'b1;
                  lat_ff <= lat_ff + lat_clamp;
                  if (!req_ok) err_ff <= err_ff + 1'b1;
                  if (req_now_sec != last_ff) begin
                     bucket_ff <= '0;
                     flush_b_ff <= bucket_inc;
                     flush_now_ff <= req_now_sec;
                  end else bucket_ff <= bucket_inc;
               end
               OP_AUTH:      auth_ff <= auth_ff + 1'b1;
               OP_RATELIMIT: rl_ff <= rl_ff + 1'b1;
               OP_READ: begin
                  if (!div_read) begin
                     rsp_valid_ff <= 1'b1;
                     rsp_data_ff <= plain_val;
                  end
               end
               OP_CLEAR: begin
                  total_ff <= '0; err_ff <= '0; auth_ff <= '0; rl_ff <= '0;
                  lat_ff <= '0; bucket_ff <= '0; peak_ff <= '0;
                  hsum_ff <= '0; pos_ff <= '0; last_ff <= req_now_sec;
                  for (int i = 0; i < 5; i++) type_ff[i] <= '0;
               end
               default: ;
            endcase
         end
         if (state_ff == ST_FLUSH_WR) begin
            if (flush_b_ff > peak_ff) peak_ff <= flush_b_ff;
            hsum_ff <= hsum_new;
            pos_ff <= (pos_ff == PosLast) ? '0 : pos_ff + 1'b1;
            last_ff <= flush_now_ff;
         end
         if (state_ff == ST_DIV && drsp.done) begin
            rsp_valid_ff <= 1'b1;
            rsp_data_ff <= drsp.quotient;
         end
      end
   end

   `RMQ_ASSERT_IMP(a_no_accept_busy, clock, reset, state_ff != ST_IDLE, !accept)
   `RMQ_ASSERT_NEXT(a_flush_seq, clock, reset, state_ff == ST_FLUSH_RD,
      state_ff == ST_FLUSH_WR)
   `RMQ_ASSERT_NEXT(a_flush_done, clock, reset, state_ff == ST_FLUSH_WR,
      state_ff == ST_IDLE)
   `RMQ_ASSERT_IMP(a_pos_range, clock, reset, 1'b1, pos_ff <= PosLast)
endmodule

// ===== rtl/rmqps_div.sv =====
// ----------------------------------------------------------------------------
// rmqps_div
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rmqps_div (
   input  logic                 clock,
   input  logic                 reset,
   input  rmqps_pkg::div_req_type req,
   output rmqps_pkg::div_rsp_type rsp
);
   import rmqps_pkg::*;

   localparam int CntBits = $clog2(CntWidth + 1);

   logic [CntWidth-1:0] quo_ff, quo_in;
   logic [CntWidth-1:0] rem_ff, rem_in;
   logic [CntWidth-1:0] dsr_ff, dsr_in;
   logic [CntBits-1:0]  cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CntWidth:0]   trial;

   // shift one dividend bit into the remainder and try a subtract
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[CntWidth-1]} - {1'b0, dsr_ff};
      if (req.start) begin
         quo_in  = req.dividend;
         rem_in  = '0;
         dsr_in  = req.divisor;
         cnt_in  = CntBits'(CntWidth);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[CntWidth]) begin
            rem_in = trial[CntWidth-1:0];
            quo_in = {quo_ff[CntWidth-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[CntWidth-2:0], quo_ff[CntWidth-1]};
            quo_in = {quo_ff[CntWidth-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntBits'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;
endmodule

// ===== dv/tb_request_metrics_rolling_qps_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_request_metrics_rolling_qps_top
// Drives request, auth, rate-limit, read and clear events into the request
// monitor and compares every counter read against an in-bench rate model.
// ----------------------------------------------------------------------------
module tb_request_metrics_rolling_qps_top;
   import rmqps_pkg::*;

   localparam int Depth = HistoryDepthDefault;

   // Hold the monitor state and the queue of pending counter reads
   class counter_scoreboard;
      logic [15:0] codes [4];
      logic [63:0] req_cnt, err_cnt, auth_cnt, rl_cnt, lat_acc, bucket, peak, avg, hsum;
      logic [63:0] class_cnt [5];
      logic [63:0] ring [Depth];
      logic [31:0] last_sec;
      int          pos;
      logic [63:0] pending_reads [$];
      int          errors;

      function void clear_all(logic [31:0] now);
         req_cnt = 0; err_cnt = 0; auth_cnt = 0; rl_cnt = 0; lat_acc = 0;
         bucket = 0; peak = 0; avg = 0; hsum = 0; pos = 0; last_sec = now;
         foreach (class_cnt[i]) class_cnt[i] = 0;
         foreach (ring[i]) ring[i] = 0;
      endfunction

      function void reset_state();
         for (int i = 0; i < 4; i++) codes[i] = 16'(i + 1);
         clear_all(0);
         errors = 0;
      endfunction

      function logic [63:0] select_counter(logic [3:0] sel);
         case (sel)
            SEL_TOTAL:  return req_cnt;
            SEL_REG:    return class_cnt[0];
            SEL_LOOKUP: return class_cnt[1];
            SEL_HB:     return class_cnt[2];
            SEL_UNREG:  return class_cnt[3];
            SEL_ERR:    return err_cnt;
            SEL_AUTH:   return auth_cnt;
            SEL_RL:     return rl_cnt;
            SEL_PEAK:   return peak;
            SEL_AVG:    return avg;
            SEL_AVGLAT: return (req_cnt != 0) ? lat_acc / req_cnt : 64'd0;
            default:    return 64'd0;
         endcase
      endfunction

      // Advance the model by one accepted transaction
      function void note_event(logic [2:0] op, logic [15:0] kind, logic signed [31:0] lat,
                               logic ok, logic [31:0] now, logic [3:0] sel);
         int cls;
         case (op)
            OP_REQUEST: begin
               cls = 4;
               for (int i = 3; i >= 0; i--) if (kind == codes[i]) cls = i;
               req_cnt++;
               class_cnt[cls]++;
               if (lat >= 0) lat_acc += {32'd0, lat};
               bucket++;
               if (!ok) err_cnt++;
               if (now != last_sec) begin
                  if (bucket > peak) peak = bucket;
                  hsum = hsum - ring[pos] + bucket;
                  ring[pos] = bucket;
                  pos = (pos + 1 >= Depth) ? 0 : pos + 1;
                  avg = hsum / Depth;
                  bucket = 0;
                  last_sec = now;
               end
            end
            OP_AUTH:      auth_cnt++;
            OP_RATELIMIT: rl_cnt++;
            OP_READ:      pending_reads.push_back(select_counter(sel));
            OP_CLEAR:     clear_all(now);
            default: ;
         endcase
      endfunction

      task report(string what, logic [63:0] got, logic [63:0] want);
         $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $time);
         errors++;
      endtask

      task check_result(logic [63:0] got);
         logic [63:0] want;
         if (pending_reads.size() == 0) begin
            report("unexpected result", got, 0);
            return;
         end
         want = pending_reads.pop_front();
         if (got !== want) report("counter_value mismatch", got, want);
      endtask
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic [2:0]  req_op = 0;
   logic [15:0] req_msg_kind = 0;
   logic signed [31:0] req_latency = 0;
   logic        req_ok = 0;
   logic [31:0] req_now_sec = 0;
   logic [3:0]  req_counter_sel = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [63:0] rsp_counter_value;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [1:0]  csr_index = 0;
   logic [15:0] csr_data = 0;

   counter_scoreboard board = new();
   bit          hold_rsp = 0;
   bit          rsp_random = 1;
   logic [31:0] cur_sec = 0;

   request_metrics_rolling_qps_top u_top (.*);

   always #1 clock = ~clock;

   // Check every accepted result
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_result(rsp_counter_value);
   end

   // Stall the result channel: a random wait per transaction, or a long hold when asked
   initial begin
      int w;
      w = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall) w = rsp_random ? $urandom_range(0, 5) : 0;
         if (hold_rsp) rsp_stall <= 1;
         else if (w > 0) begin
            rsp_stall <= 1;
            w--;
         end else rsp_stall <= 0;
      end
   end

   task automatic send_event(logic [2:0] op, logic [15:0] kind, logic [31:0] lat,
                             logic ok, logic [31:0] now, logic [3:0] sel, bit gaps);
      int g;
      g = gaps ? $urandom_range(0, 5) : 0;
      if (g > 0) begin
         req_valid <= 0;
         repeat (g) @(posedge clock);
      end
      req_valid <= 1; req_op <= op; req_msg_kind <= kind; req_latency <= lat;
      req_ok <= ok; req_now_sec <= now; req_counter_sel <= sel;
      do @(posedge clock); while (req_stall);
      board.note_event(op, kind, lat, ok, now, sel);
   endtask

   task automatic write_code(logic [1:0] idx, logic [15:0] val);
      csr_valid <= 1; csr_index <= idx; csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      board.codes[idx] = val;
      csr_valid <= 0;
      @(posedge clock);
   endtask

   // Wait until every read has returned, then let the block drain
   task automatic drain();
      req_valid <= 0;
      while (board.pending_reads.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   // Random transaction, mostly requests within a few seconds
   task automatic random_event(bit gaps);
      int r;
      logic [2:0] op;
      logic [15:0] kind;
      r = $urandom_range(0, 99);
      if (r < 60) op = OP_REQUEST;
      else if (r < 66) op = OP_AUTH;
      else if (r < 72) op = OP_RATELIMIT;
      else if (r < 96) op = OP_READ;
      else if (r < 98) op = OP_CLEAR;
      else op = 3'($urandom_range(5, 7));
      if ($urandom_range(0, 9) < 7) kind = board.codes[$urandom_range(0, 3)];
      else kind = 16'($urandom);
      if ($urandom_range(0, 3) == 0) cur_sec = ($urandom_range(0, 9) == 0) ? $urandom
                                                                           : cur_sec + 1;
      send_event(op, kind, $urandom, 1'($urandom), cur_sec, 4'($urandom_range(0, 15)),
                 gaps);
   endtask

   initial begin
      board.reset_state();
      repeat (11) @(posedge clock);
      reset <= 0;
      // Directed: config extremes, duplicates, every op and read index
      write_code(0, 16'hffff); write_code(1, 16'h0000);
      write_code(2, 16'hffff); write_code(3, 16'h8000);
      send_event(OP_READ, 0, 0, 1, 0, SEL_AVGLAT, 0);
      send_event(OP_REQUEST, 16'hffff, 32'h7fffffff, 1, 0, 0, 0);
      send_event(OP_REQUEST, 16'h0000, 32'h80000000, 0, 0, 0, 0);
      send_event(OP_REQUEST, 16'h8000, 32'hffffffff, 1, 1, 0, 0);
      send_event(OP_REQUEST, 16'h1234, 32'd5, 0, 32'hffffffff, 0, 0);
      send_event(OP_AUTH, 0, 0, 0, 0, 0, 0);
      send_event(OP_RATELIMIT, 0, 0, 0, 0, 0, 0);
      send_event(3'd5, 0, 0, 0, 0, 0, 0);
      send_event(3'd7, 16'hffff, 32'hffffffff, 1, 32'hffffffff, 4'hf, 0);
      for (int s = 0; s < 16; s++) send_event(OP_READ, 0, 0, 0, 0, 4'(s), 0);
      send_event(OP_CLEAR, 0, 0, 0, 32'd77, 0, 0);
      send_event(OP_READ, 0, 0, 0, 0, SEL_AVGLAT, 0);
      drain();
      // Random phases under several code settings
      for (int ph = 0; ph < 4; ph++) begin
         if (ph == 1) begin
            write_code(0, 1); write_code(1, 2); write_code(2, 3); write_code(3, 4);
         end else if (ph > 1) begin
            for (int i = 0; i < 4; i++) write_code(2'(i), 16'($urandom_range(0, 7)));
         end
         if (ph == 2) begin
            // Hold off the receiver while reads pile up behind it
            fork
               begin hold_rsp = 1; repeat (400) @(posedge clock); hold_rsp = 0; end
               for (int k = 0; k < 40; k++) send_event(OP_READ, 0, 0, 0, 0,
                                                       4'($urandom_range(0, 8)), 0);
            join
         end
         rsp_random = (ph != 3);
         for (int k = 0; k < 320; k++) random_event(ph != 3 || k > 160);
         drain();
      end
      if (board.pending_reads.size() == 0 && board.errors == 0)
         $display("request_metrics_rolling_qps_top verification clean");
      else
         $display("request_metrics_rolling_qps_top verification failed");
      $finish;
   end

   initial begin
      #2000000;
      $display("request_metrics_rolling_qps_top verification failed");
      $finish;
   end
endmodule
